FILE: hw/rtl/css_color_string_parser_unit_macros.svh
// Assertion macros shared by the color string parser RTL.
`ifndef CSS_COLOR_STRING_PARSER_UNIT_MACROS_SVH
`define CSS_COLOR_STRING_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CSSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CSSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/cssp_pkg.sv
// Package: types, constants and the named color ROM of the color string parser.
`default_nettype none
package cssp_pkg;

    localparam int MAX_NAME_CHARS_DEF = 20;
    localparam int NAME_COUNT_DEF     = 148;
    localparam int ROM_SIZE           = 148;
    localparam int LABEL_CHARS        = 20;
    localparam int ROM_IDX_W          = 8;
    localparam logic [7:0] CHAR_HASH  = 8'h23;

    typedef struct packed {
        logic [LABEL_CHARS*8-1:0] label;   // right aligned, last char in low byte
        logic [23:0]              rgb;
    } rom_entry_t;

    typedef struct packed {
        logic take;       // store the word's character
        logic load_hex;   // result from the hex accumulator
        logic load_rom;   // result from the current ROM entry
        logic load_bad;   // invalid result
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic overflow;
        logic hash;
        logic hex_ok;
        logic match;
    } status_t;

    function automatic logic [7:0] fold(input logic [7:0] c);
        fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic rom_entry_t rom_entry(input logic [ROM_IDX_W-1:0] idx);
        rom_entry_t e;
        case (idx)
            8'd0:   e = '{"aliceblue", 24'hf0f8ff};
            8'd1:   e = '{"antiquewhite", 24'hfaebd7};
            8'd2:   e = '{"aqua", 24'h00ffff};
            8'd3:   e = '{"aquamarine", 24'h7fffd4};
            8'd4:   e = '{"azure", 24'hf0ffff};
            8'd5:   e = '{"beige", 24'hf5f5dc};
            8'd6:   e = '{"bisque", 24'hffe4c4};
            8'd7:   e = '{"black", 24'h000000};
            8'd8:   e = '{"blanchedalmond", 24'hffebcd};
            8'd9:   e = '{"blue", 24'h0000ff};
            8'd10:  e = '{"blueviolet", 24'h8a2be2};
            8'd11:  e = '{"brown", 24'ha52a2a};
            8'd12:  e = '{"burlywood", 24'hdeb887};
            8'd13:  e = '{"cadetblue", 24'h5f9ea0};
            8'd14:  e = '{"chartreuse", 24'h7fff00};
            8'd15:  e = '{"chocolate", 24'hd2691e};
            8'd16:  e = '{"coral", 24'hff7f50};
            8'd17:  e = '{"cornflowerblue", 24'h6495ed};
            8'd18:  e = '{"cornsilk", 24'hfff8dc};
            8'd19:  e = '{"crimson", 24'hdc143c};
            8'd20:  e = '{"cyan", 24'h00ffff};
            8'd21:  e = '{"darkblue", 24'h00008b};
            8'd22:  e = '{"darkcyan", 24'h008b8b};
            8'd23:  e = '{"darkgoldenrod", 24'hb8860b};
            8'd24:  e = '{"darkgray", 24'ha9a9a9};
            8'd25:  e = '{"darkgreen", 24'h006400};
            8'd26:  e = '{"darkgrey", 24'ha9a9a9};
            8'd27:  e = '{"darkkhaki", 24'hbdb76b};
            8'd28:  e = '{"darkmagenta", 24'h8b008b};
            8'd29:  e = '{"darkolivegreen", 24'h556b2f};
            8'd30:  e = '{"darkorange", 24'hff8c00};
            8'd31:  e = '{"darkorchid", 24'h9932cc};
            8'd32:  e = '{"darkred", 24'h8b0000};
            8'd33:  e = '{"darksalmon", 24'he9967a};
            8'd34:  e = '{"darkseagreen", 24'h8fbc8f};
            8'd35:  e = '{"darkslateblue", 24'h483d8b};
            8'd36:  e = '{"darkslategray", 24'h2f4f4f};
            8'd37:  e = '{"darkslategrey", 24'h2f4f4f};
            8'd38:  e = '{"darkturquoise", 24'h00ced1};
            8'd39:  e = '{"darkviolet", 24'h9400d3};
            8'd40:  e = '{"deeppink", 24'hff1493};
            8'd41:  e = '{"deepskyblue", 24'h00bfff};
            8'd42:  e = '{"dimgray", 24'h696969};
            8'd43:  e = '{"dimgrey", 24'h696969};
            8'd44:  e = '{"dodgerblue", 24'h1e90ff};
            8'd45:  e = '{"firebrick", 24'hb22222};
            8'd46:  e = '{"floralwhite", 24'hfffaf0};
            8'd47:  e = '{"forestgreen", 24'h228b22};
            8'd48:  e = '{"fuchsia", 24'hff00ff};
            8'd49:  e = '{"gainsboro", 24'hdcdcdc};
            8'd50:  e = '{"ghostwhite", 24'hf8f8ff};
            8'd51:  e = '{"gold", 24'hffd700};
            8'd52:  e = '{"goldenrod", 24'hdaa520};
            8'd53:  e = '{"gray", 24'h808080};
            8'd54:  e = '{"green", 24'h008000};
            8'd55:  e = '{"greenyellow", 24'hadff2f};
            8'd56:  e = '{"grey", 24'h808080};
            8'd57:  e = '{"honeydew", 24'hf0fff0};
            8'd58:  e = '{"hotpink", 24'hff69b4};
            8'd59:  e = '{"indianred", 24'hcd5c5c};
            8'd60:  e = '{"indigo", 24'h4b0082};
            8'd61:  e = '{"ivory", 24'hfffff0};
            8'd62:  e = '{"khaki", 24'hf0e68c};
            8'd63:  e = '{"lavender", 24'he6e6fa};
            8'd64:  e = '{"lavenderblush", 24'hfff0f5};
            8'd65:  e = '{"lawngreen", 24'h7cfc00};
            8'd66:  e = '{"lemonchiffon", 24'hfffacd};
            8'd67:  e = '{"lightblue", 24'hadd8e6};
            8'd68:  e = '{"lightcoral", 24'hf08080};
            8'd69:  e = '{"lightcyan", 24'he0ffff};
            8'd70:  e = '{"lightgoldenrodyellow", 24'hfafad2};
            8'd71:  e = '{"lightgray", 24'hd3d3d3};
            8'd72:  e = '{"lightgreen", 24'h90ee90};
            8'd73:  e = '{"lightgrey", 24'hd3d3d3};
            8'd74:  e = '{"lightpink", 24'hffb6c1};
            8'd75:  e = '{"lightsalmon", 24'hffa07a};
            8'd76:  e = '{"lightseagreen", 24'h20b2aa};
            8'd77:  e = '{"lightskyblue", 24'h87cefa};
            8'd78:  e = '{"lightslategray", 24'h778899};
            8'd79:  e = '{"lightslategrey", 24'h778899};
            8'd80:  e = '{"lightsteelblue", 24'hb0c4de};
            8'd81:  e = '{"lightyellow", 24'hffffe0};
            8'd82:  e = '{"lime", 24'h00ff00};
            8'd83:  e = '{"limegreen", 24'h32cd32};
            8'd84:  e = '{"linen", 24'hfaf0e6};
            8'd85:  e = '{"magenta", 24'hff00ff};
            8'd86:  e = '{"maroon", 24'h800000};
            8'd87:  e = '{"mediumaquamarine", 24'h66cdaa};
            8'd88:  e = '{"mediumblue", 24'h0000cd};
            8'd89:  e = '{"mediumorchid", 24'hba55d3};
            8'd90:  e = '{"mediumpurple", 24'h9370db};
            8'd91:  e = '{"mediumseagreen", 24'h3cb371};
            8'd92:  e = '{"mediumslateblue", 24'h7b68ee};
            8'd93:  e = '{"mediumspringgreen", 24'h00fa9a};
            8'd94:  e = '{"mediumturquoise", 24'h48d1cc};
            8'd95:  e = '{"mediumvioletred", 24'hc71585};
            8'd96:  e = '{"midnightblue", 24'h191970};
            8'd97:  e = '{"mintcream", 24'hf5fffa};
            8'd98:  e = '{"mistyrose", 24'hffe4e1};
            8'd99:  e = '{"moccasin", 24'hffe4b5};
            8'd100: e = '{"navajowhite", 24'hffdead};
            8'd101: e = '{"navy", 24'h000080};
            8'd102: e = '{"oldlace", 24'hfdf5e6};
            8'd103: e = '{"olive", 24'h808000};
            8'd104: e = '{"olivedrab", 24'h6b8e23};
            8'd105: e = '{"orange", 24'hffa500};
            8'd106: e = '{"orangered", 24'hff4500};
            8'd107: e = '{"orchid", 24'hda70d6};
            8'd108: e = '{"palegoldenrod", 24'heee8aa};
            8'd109: e = '{"palegreen", 24'h98fb98};
            8'd110: e = '{"paleturquoise", 24'hafeeee};
            8'd111: e = '{"palevioletred", 24'hdb7093};
            8'd112: e = '{"papayawhip", 24'hffefd5};
            8'd113: e = '{"peachpuff", 24'hffdab9};
            8'd114: e = '{"peru", 24'hcd853f};
            8'd115: e = '{"pink", 24'hffc0cb};
            8'd116: e = '{"plum", 24'hdda0dd};
            8'd117: e = '{"powderblue", 24'hb0e0e6};
            8'd118: e = '{"purple", 24'h800080};
            8'd119: e = '{"rebeccapurple", 24'h663399};
            8'd120: e = '{"red", 24'hff0000};
            8'd121: e = '{"rosybrown", 24'hbc8f8f};
            8'd122: e = '{"royalblue", 24'h4169e1};
            8'd123: e = '{"saddlebrown", 24'h8b4513};
            8'd124: e = '{"salmon", 24'hfa8072};
            8'd125: e = '{"sandybrown", 24'hf4a460};
            8'd126: e = '{"seagreen", 24'h2e8b57};
            8'd127: e = '{"seashell", 24'hfff5ee};
            8'd128: e = '{"sienna", 24'ha0522d};
            8'd129: e = '{"silver", 24'hc0c0c0};
            8'd130: e = '{"skyblue", 24'h87ceeb};
            8'd131: e = '{"slateblue", 24'h6a5acd};
            8'd132: e = '{"slategray", 24'h708090};
            8'd133: e = '{"slategrey", 24'h708090};
            8'd134: e = '{"snow", 24'hfffafa};
            8'd135: e = '{"springgreen", 24'h00ff7f};
            8'd136: e = '{"steelblue", 24'h4682b4};
            8'd137: e = '{"tan", 24'hd2b48c};
            8'd138: e = '{"teal", 24'h008080};
            8'd139: e = '{"thistle", 24'hd8bfd8};
            8'd140: e = '{"tomato", 24'hff6347};
            8'd141: e = '{"turquoise", 24'h40e0d0};
            8'd142: e = '{"violet", 24'hee82ee};
            8'd143: e = '{"wheat", 24'hf5deb3};
            8'd144: e = '{"white", 24'hffffff};
            8'd145: e = '{"whitesmoke", 24'hf5f5f5};
            8'd146: e = '{"yellow", 24'hffff00};
            8'd147: e = '{"yellowgreen", 24'h9acd32};
            default: e = '0;   // empty label matches nothing
        endcase
        rom_entry = e;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/cssp_if.sv
// Valid/ready channel interfaces for characters and results.
`default_nettype none
interface cssp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       has_char;
    logic       last;
    modport source (output valid, character, has_char, last, input ready);
    modport sink   (input valid, character, has_char, last, output ready);
endinterface

interface cssp_result_if;
    logic        valid;
    logic        ready;
    logic [23:0] rgb_value;
    logic        is_valid;
    modport source (output valid, rgb_value, is_valid, input ready);
    modport sink   (input valid, rgb_value, is_valid, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/css_color_string_parser_unit.sv
// Top level of the CSS color string parser: hex and named color decode.
//
//  channel  | dir  | payload                          | accepted when
//  ---------+------+----------------------------------+----------------------
//  chars    | sink | character[8], has_char, last     | valid && ready
//  result   | src  | rgb_value[24], is_valid          | valid && ready
//
// A word with last set closes the string: a decision state follows, then
// hex strings go straight to the result register, while names sweep the
// color ROM one entry per cycle (at most NAME_COUNT entries, stopping at
// the first hit). The sweep is set by the single ROM compare unit, which
// checks all positions of one entry.
// The result word is held until taken; intake stays closed until then.
// Reset (rst_n low, asynchronous) empties the string state and the FSM.
`default_nettype none
module css_color_string_parser_unit #(
    parameter int MAX_NAME_CHARS = cssp_pkg::MAX_NAME_CHARS_DEF,
    parameter int NAME_COUNT     = cssp_pkg::NAME_COUNT_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    cssp_char_if.sink      chars,
    cssp_result_if.source  result
);
    cssp_pkg::cmd_t                      cmd;
    cssp_pkg::status_t                   status;
    logic [cssp_pkg::ROM_IDX_W-1:0]      rom_idx;

    cssp_controller #(
        .NAME_COUNT (NAME_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chars.valid),
        .has_char  (chars.has_char),
        .last      (chars.last),
        .in_ready  (chars.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd),
        .rom_idx   (rom_idx)
    );

    cssp_datapath #(
        .MAX_NAME_CHARS (MAX_NAME_CHARS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rom_idx   (rom_idx),
        .character (chars.character),
        .status    (status),
        .rgb_value (result.rgb_value),
        .is_valid  (result.is_valid)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/cssp_datapath.sv
// Datapath: name shift buffer, hex accumulator, ROM compare, result register.
`default_nettype none
module cssp_datapath #(
    parameter int MAX_NAME_CHARS = cssp_pkg::MAX_NAME_CHARS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire cssp_pkg::cmd_t                   cmd,
    input  wire logic [cssp_pkg::ROM_IDX_W-1:0]   rom_idx,
    input  wire logic [7:0]                       character,
    output cssp_pkg::status_t                     status,
    output logic [23:0]                           rgb_value,
    output logic                                  is_valid
);
    localparam int CW = $clog2(MAX_NAME_CHARS + 1);
    localparam int NW = (MAX_NAME_CHARS > cssp_pkg::LABEL_CHARS) ?
                        MAX_NAME_CHARS : cssp_pkg::LABEL_CHARS;

    logic [7:0]    buf_reg [MAX_NAME_CHARS];   // buf_reg[0] holds the newest char
    logic [CW-1:0] count_reg, count_next;
    logic [23:0]   acc_reg, acc_next;
    logic          hash_reg, hash_next;
    logic          digits_reg, digits_next;
    logic          ovf_reg, ovf_next;
    logic [23:0]   rgb_reg, rgb_next;
    logic          valid_reg, valid_next;

    logic       full;
    logic       nib_ok;
    logic [3:0] nib;
    logic [7:0] lab_b [NW];
    logic [7:0] buf_b [NW];
    logic       match;
    cssp_pkg::rom_entry_t ent;
    logic [23:0] wide;

    assign full = (count_reg == CW'(MAX_NAME_CHARS));

    always_comb
    begin
        nib_ok = 1'b1;
        nib    = character[3:0];
        if (character inside {[8'h30:8'h39]})
            nib = character[3:0];
        else if (character inside {[8'h61:8'h66], [8'h41:8'h46]})
            nib = character[3:0] + 4'd9;
        else
            nib_ok = 1'b0;
    end

    // one ROM entry per cycle, all positions compared at once
    always_comb
    begin
        ent = cssp_pkg::rom_entry(rom_idx);
        for (int k = 0; k < NW; k++)
        begin
            lab_b[k] = 8'd0;
            buf_b[k] = 8'd0;
            if (k < cssp_pkg::LABEL_CHARS)
                lab_b[k] = ent.label[k*8 +: 8];
            if (k < MAX_NAME_CHARS)
                buf_b[k] = cssp_pkg::fold(buf_reg[k]);
        end
        match = 1'b1;
        for (int k = 0; k < NW; k++)
        begin
            if (k < int'(count_reg))
            begin
                if (lab_b[k] == 8'd0 || lab_b[k] != buf_b[k])
                    match = 1'b0;
            end
            else if (lab_b[k] != 8'd0)
                match = 1'b0;
        end
    end

    assign wide = {acc_reg[11:8], acc_reg[11:8], acc_reg[7:4], acc_reg[7:4],
                   acc_reg[3:0], acc_reg[3:0]};

    always_comb
    begin
        count_next  = count_reg;
        acc_next    = acc_reg;
        hash_next   = hash_reg;
        digits_next = digits_reg;
        ovf_next    = ovf_reg;
        rgb_next    = rgb_reg;
        valid_next  = valid_reg;
        if (cmd.take)
        begin
            if (full)
                ovf_next = 1'b1;
            else
            begin
                count_next = count_reg + CW'(1);
                if (count_reg == '0)
                    hash_next = (character == cssp_pkg::CHAR_HASH);
                else if (hash_reg)
                begin
                    if (nib_ok)
                        acc_next = {acc_reg[19:0], nib};
                    else
                        digits_next = 1'b0;
                end
            end
        end
        if (cmd.load_hex || cmd.load_rom || cmd.load_bad)
        begin
            valid_next  = !cmd.load_bad;
            rgb_next    = cmd.load_bad ? 24'd0 :
                          cmd.load_rom ? ent.rgb :
                          (count_reg == CW'(7)) ? acc_reg : wide;
            count_next  = '0;
            acc_next    = '0;
            hash_next   = 1'b0;
            digits_next = 1'b1;
            ovf_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            acc_reg    <= '0;
            hash_reg   <= 1'b0;
            digits_reg <= 1'b1;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            acc_reg    <= acc_next;
            hash_reg   <= hash_next;
            digits_reg <= digits_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rgb_reg   <= rgb_next;
        valid_reg <= valid_next;
        if (cmd.take && !full)
        begin
            buf_reg[0] <= character;
            for (int k = 1; k < MAX_NAME_CHARS; k++)
                buf_reg[k] <= buf_reg[k-1];
        end
    end

    assign status.empty    = (count_reg == '0);
    assign status.overflow = ovf_reg;
    assign status.hash     = hash_reg;
    assign status.hex_ok   = digits_reg && (count_reg == CW'(7) || count_reg == CW'(4));
    assign status.match    = match;
    assign rgb_value       = rgb_reg;
    assign is_valid        = valid_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/cssp_controller.sv
// Controller: character intake, end-of-string decision and ROM sweep.
`default_nettype none
module cssp_controller #(
    parameter int NAME_COUNT = cssp_pkg::NAME_COUNT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic                            has_char,
    input  wire logic                            last,
    output logic                                 in_ready,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    input  wire cssp_pkg::status_t               status,
    output cssp_pkg::cmd_t                       cmd,
    output logic [cssp_pkg::ROM_IDX_W-1:0]       rom_idx
);
    localparam int IW = (NAME_COUNT > 1) ? $clog2(NAME_COUNT) : 1;

    typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_SEARCH, S_RESULT} state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          acc_in;
    logic          idx_end;

    assign acc_in  = in_valid && in_ready;
    assign idx_end = (idx_reg == IW'(NAME_COUNT - 1));

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.take     = acc_in && has_char;
        case (state_reg)
            S_IDLE:
            begin
                if (acc_in && last)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                idx_next = '0;
                if (status.empty || status.overflow)
                begin
                    cmd.load_bad = 1'b1;
                    state_next   = S_RESULT;
                end
                else if (status.hash)
                begin
                    cmd.load_hex = status.hex_ok;
                    cmd.load_bad = !status.hex_ok;
                    state_next   = S_RESULT;
                end
                else
                    state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (status.match)
                begin
                    cmd.load_rom = 1'b1;
                    state_next   = S_RESULT;
                end
                else if (idx_end)
                begin
                    cmd.load_bad = 1'b1;
                    state_next   = S_RESULT;
                end
                else
                    idx_next = idx_reg + IW'(1);
            end
            S_RESULT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESULT);
    assign rom_idx   = cssp_pkg::ROM_IDX_W'(idx_reg);

`include "css_color_string_parser_unit_macros.svh"

    `CSSP_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "intake open while result pending")
    `CSSP_ASSERT_NEXT(a_result_drains, out_valid && out_ready, in_ready, "no return to intake")
    `CSSP_ASSERT_NOW(a_one_load, 1'b1, $countones({cmd.load_hex, cmd.load_rom, cmd.load_bad}) <= 1,
                     "conflicting result loads")
    `CSSP_ASSERT_NEXT(a_last_decides, acc_in && last, state_reg == S_DECIDE,
                      "end of string not taken")

endmodule
`default_nettype wire

FILE: bench/cssp_tb_if.sv
// Testbench copies of nothing: interfaces come from the RTL; this file holds bench helpers.
`timescale 1ns / 100ps
package cssp_tb_pkg;

    // One accepted result word.
    typedef struct {
        logic [23:0] rgb_value;
        logic        is_valid;
    } color_result_t;

    // Tracks the string being built and the colors still owed by the block.
    class color_scoreboard;
        logic [7:0]    str_bytes[$];
        bit            too_long;
        color_result_t owed[$];
        int            errors;

        function automatic logic [7:0] lower(input logic [7:0] c);
            return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        endfunction

        function automatic int hex_val(input logic [7:0] c);
            if (c >= "0" && c <= "9") return c - "0";
            if (c >= "a" && c <= "f") return c - "a" + 10;
            if (c >= "A" && c <= "F") return c - "A" + 10;
            return -1;
        endfunction

        function automatic color_result_t decode_string();
            color_result_t r;
            logic [23:0]   acc;
            bit            good;
            bit            hit;
            int            v;
            string         t;
            r = '{24'h0, 1'b0};
            if (str_bytes.size() == 0 || too_long) return r;
            if (str_bytes[0] == cssp_pkg::CHAR_HASH) begin
                acc = '0;
                good = 1;
                for (int i = 1; i < str_bytes.size(); i++) begin
                    v = hex_val(str_bytes[i]);
                    if (v < 0) good = 0;
                    else acc = {acc[19:0], v[3:0]};
                end
                if (good && str_bytes.size() == 7) r = '{acc, 1'b1};
                else if (good && str_bytes.size() == 4)
                    r = '{{acc[11:8], acc[11:8], acc[7:4], acc[7:4], acc[3:0], acc[3:0]},
                          1'b1};
                return r;
            end
            // byte by byte, so a zero byte in the name never matches
            for (int k = 0; k < cssp_pkg::ROM_SIZE; k++) begin
                t = color_name(k);
                hit = (t.len() == str_bytes.size());
                for (int i = 0; i < t.len() && hit; i++)
                    if (lower(str_bytes[i]) != t[i]) hit = 0;
                if (hit) return '{color_rgb(k), 1'b1};
            end
            return r;
        endfunction

        // Label of ROM entry k as a string, from the package table (data only).
        function automatic string color_name(input int k);
            cssp_pkg::rom_entry_t e;
            string t;
            e = cssp_pkg::rom_entry(k[7:0]);
            t = "";
            for (int b = cssp_pkg::LABEL_CHARS - 1; b >= 0; b--)
                if (e.label[b*8 +: 8] != 8'h00) t = {t, string'(e.label[b*8 +: 8])};
            return t;
        endfunction

        function automatic logic [23:0] color_rgb(input int k);
            cssp_pkg::rom_entry_t e;
            e = cssp_pkg::rom_entry(k[7:0]);
            return e.rgb;
        endfunction

        function void note_word(input logic [7:0] c, input bit has_char, input bit last);
            if (has_char) begin
                if (str_bytes.size() >= 20) too_long = 1;
                else str_bytes.push_back(c);
            end
            if (last) begin
                owed.push_back(decode_string());
                str_bytes.delete();
                too_long = 0;
            end
        endfunction

        function void check_result(input logic [23:0] rgb, input logic ok);
            color_result_t x;
            if (owed.size() == 0) begin
                $error("unexpected result rgb_value=%h is_valid=%b", rgb, ok);
                errors++;
                return;
            end
            x = owed.pop_front();
            if (rgb !== x.rgb_value) begin
                $error("rgb_value expected %h actual %h", x.rgb_value, rgb);
                errors++;
            end
            if (ok !== x.is_valid) begin
                $error("is_valid expected %b actual %b", x.is_valid, ok);
                errors++;
            end
        endfunction
    endclass
endpackage

FILE: bench/css_color_string_parser_unit_tb.sv
// Self-checking bench for the CSS color string parser unit.
`timescale 1ns / 100ps
module css_color_string_parser_unit_tb;
    import cssp_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 0;
    logic rst_n = 0;
    always #2 clk = ~clk;

    cssp_char_if   chars();
    cssp_result_if result();

    css_color_string_parser_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars.sink),
        .result (result.source)
    );

    color_scoreboard colors = new();
    bit     quiet_tail;     // no idling on either side near the end
    bit     hold_sink;      // long receiver hold-off for back-pressure
    int     idle_cycles;
    int     string_count;

    initial begin
        chars.valid = 0;
        chars.character = 0;
        chars.has_char = 0;
        chars.last = 0;
        result.ready = 0;
    end

    // Sampling at the rising edge: inputs accepted feed the predictor, results get checked.
    always @(posedge clk) begin
        if (rst_n) begin
            if (chars.valid && chars.ready)
                colors.note_word(chars.character, chars.has_char, chars.last);
            if (result.valid && result.ready)
                colors.check_result(result.rgb_value, result.is_valid);
            if ((chars.valid && chars.ready) || (result.valid && result.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stall bursts, a long hold when asked, none in the tail.
    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_sink) begin
                result.ready <= 0;
                repeat (300) @(negedge clk);
                hold_sink = 0;
            end
            if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 17);
                result.ready <= 0;
                repeat (n) @(negedge clk);
            end
            result.ready <= 1;
        end
    end

    // Send one word and wait for its handshake; random gap before it.
    task automatic send_word(input logic [7:0] c, input bit hc, input bit lst);
        int n;
        if (!quiet_tail && $urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, 17);
            chars.valid <= 0;
            repeat (n) @(negedge clk);
        end
        chars.valid <= 1;
        chars.character <= c;
        chars.has_char <= hc;
        chars.last <= lst;
        do @(posedge clk); while (!chars.ready);
        @(negedge clk);
    endtask

    task automatic send_string(input string s);
        if (s.len() == 0) send_word($urandom_range(0, 255), 0, 1);
        for (int i = 0; i < s.len(); i++) send_word(s[i], 1, i == s.len() - 1);
        string_count++;
    endtask

    function automatic byte rand_hex();
        string d;
        d = "0123456789abcdefABCDEF";
        return d[$urandom_range(0, 21)];
    endfunction

    function automatic string random_case(input string s);
        string t;
        t = s;
        for (int i = 0; i < t.len(); i++)
            if ($urandom_range(0, 1) && t[i] >= "a" && t[i] <= "z") t[i] = t[i] - 32;
        return t;
    endfunction

    function automatic string random_string();
        string s;
        int    kind;
        int    len;
        kind = $urandom_range(0, 9);
        s = "";
        if (kind <= 3) begin
            s = random_case(colors.color_name($urandom_range(0, 147)));
            // sometimes spoil one byte of a good name
            if ($urandom_range(0, 7) == 0) s[$urandom_range(0, s.len() - 1)] = $urandom_range(0, 255);
        end else if (kind <= 6) begin
            len = ($urandom_range(0, 1)) ? 6 : 3;
            if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 8);
            s = "#";
            for (int i = 0; i < len; i++) s = {s, string'(rand_hex())};
            if ($urandom_range(0, 7) == 0) s[$urandom_range(1, s.len() > 1 ? s.len() - 1 : 1)]
                = $urandom_range(1, 255);
        end else begin
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++) s = {s, string'(byte'($urandom_range(1, 255)))};
        end
        return s;
    endfunction

    initial begin
        int words;
        int n;
        string s;
        idle_cycles = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: hex forms, names in both cases, empty, too long, bad bytes.
        send_string("#000000");
        send_string("#FfFfFf");
        send_string("#aBc");
        send_string("#12345");
        send_string("#12g456");
        send_string("#");
        send_string("");
        send_string("AliceBlue");
        send_string("YELLOWGREEN");
        send_string("lightgoldenrodyellow");
        send_string("lightgoldenrodyellowx");
        send_string("#0123456789abcdef01234");
        send_string("re");
        // Zero byte and high byte inside a name.
        send_word("r", 1, 0); send_word(8'h00, 1, 0); send_word("d", 1, 1);
        send_word("r", 1, 0); send_word("e", 1, 0); send_word(8'hE4, 1, 1);
        // Words without a byte in the middle of a string.
        send_word("t", 1, 0); send_word(8'hFF, 0, 0); send_word("a", 1, 0);
        send_word("n", 1, 1);

        // Back-pressure: receiver holds while short strings keep coming.
        hold_sink = 1;
        for (int i = 0; i < 8; i++) send_string("red");

        words = 0;
        while (words < 1100) begin
            if (words > 950) quiet_tail = 1;
            if ($urandom_range(0, 19) == 0) begin
                // idle word, no byte
                send_word($urandom_range(0, 255), 0, $urandom_range(0, 3) == 0);
                words++;
            end else begin
                s = random_string();
                send_string(s);
                words += (s.len() == 0) ? 1 : s.len();
            end
        end
        chars.valid <= 0;

        n = 0;
        while (colors.owed.size() != 0 && n < 5000) begin
            @(posedge clk);
            n++;
        end
        repeat (200) @(posedge clk);
        if (colors.errors == 0 && colors.owed.size() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    // Watchdog: no handshake for too long ends the run.
    always @(posedge clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/cssp_pkg.sv
hw/rtl/cssp_if.sv
hw/rtl/cssp_datapath.sv
hw/rtl/cssp_controller.sv
hw/rtl/css_color_string_parser_unit.sv
bench/cssp_tb_if.sv
bench/css_color_string_parser_unit_tb.sv
